[rtl/core/hpt_pkg.sv]
// hpt_pkg: shared types and constants of the histogram with percentile threshold unit
// used by hpt_ctrl, hpt_dpath and the top level; no dependencies
package hpt_pkg;

    localparam int KIND_W     = 3;
    localparam int PIX_W      = 16;
    localparam int BIN_W      = 8;
    localparam int NUM_BINS   = 256;
    localparam int SUM_W      = 40;
    localparam int CNT_OUT_W  = 32;
    localparam int THR_W      = 9;
    localparam int WALK_W     = BIN_W + 1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int DEPTH_W    = 5;
    localparam int PCT_W      = 7;

    localparam logic [DEPTH_W-1:0] DEPTH_MIN   = 5'd8;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX   = 5'd16;
    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 5'd8;
    localparam logic [PCT_W-1:0]   PCT_FULL    = 7'd100;
    localparam logic [THR_W-1:0]   THR_NONE    = 9'd256;
    localparam logic [THR_W-1:0]   THR_MIN     = 9'd1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_DEPTH       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_PIXELS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_PERCENT = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR     = 3'd0,
        KIND_PIXEL     = 3'd1,
        KIND_END_FRAME = 3'd2,
        KIND_READ_BIN  = 3'd3,
        KIND_THRESHOLD = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PIX,
        ST_READ,
        ST_WALK
    } t_state;

    typedef struct packed {
        logic             clear;
        logic             pix_load;
        logic             pix_upd;
        logic             swap;
        logic             rd_issue;
        logic             rd_emit;
        logic             th_init;
        logic             walk_issue;
        logic             th_emit;
        logic             emit_now;
        logic [BIN_W-1:0] walk_addr;
    } t_cmd;

    typedef struct packed {
        logic found;
        logic pipe_busy;
    } t_stat;

endpackage

[rtl/core/hpt_ctrl.sv]
// hpt_ctrl: command decoder and sequencer, including the threshold walk counter
// depends on hpt_pkg; drives hpt_dpath through a command struct
module hpt_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [hpt_pkg::KIND_W-1:0] i_kind,
    input  hpt_pkg::t_stat             i_stat,
    output hpt_pkg::t_cmd              o_cmd,
    output logic                       o_busy
);

    hpt_pkg::t_state                r_state, n_state;
    logic [hpt_pkg::WALK_W-1:0]     r_walk_cnt, n_walk_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= hpt_pkg::ST_IDLE;
            r_walk_cnt <= '0;
        end else begin
            r_state    <= n_state;
            r_walk_cnt <= n_walk_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_walk_cnt = r_walk_cnt;
        o_cmd      = '0;
        o_cmd.walk_addr = r_walk_cnt[hpt_pkg::BIN_W-1:0];
        o_busy     = (r_state != hpt_pkg::ST_IDLE);
        unique case (r_state)
            hpt_pkg::ST_IDLE: begin
                if (i_start) begin
                    unique case (hpt_pkg::t_kind'(i_kind))
                        hpt_pkg::KIND_CLEAR: begin
                            o_cmd.clear    = 1'b1;
                            o_cmd.emit_now = 1'b1;
                        end
                        hpt_pkg::KIND_PIXEL: begin
                            o_cmd.pix_load = 1'b1;
                            n_state        = hpt_pkg::ST_PIX;
                        end
                        hpt_pkg::KIND_END_FRAME: begin
                            o_cmd.swap     = 1'b1;
                            o_cmd.emit_now = 1'b1;
                        end
                        hpt_pkg::KIND_READ_BIN: begin
                            o_cmd.rd_issue = 1'b1;
                            n_state        = hpt_pkg::ST_READ;
                        end
                        hpt_pkg::KIND_THRESHOLD: begin
                            o_cmd.th_init  = 1'b1;
                            n_walk_cnt     = '0;
                            n_state        = hpt_pkg::ST_WALK;
                        end
                        default: begin
                            o_cmd.emit_now = 1'b1;
                        end
                    endcase
                end
            end
            hpt_pkg::ST_PIX: begin
                o_cmd.pix_upd = 1'b1;
                n_state       = hpt_pkg::ST_IDLE;
            end
            hpt_pkg::ST_READ: begin
                o_cmd.rd_emit = 1'b1;
                n_state       = hpt_pkg::ST_IDLE;
            end
            hpt_pkg::ST_WALK: begin
                // end once a bin crossed the limit, or all bins issued and none in flight
                if (i_stat.found || (r_walk_cnt[hpt_pkg::BIN_W] && !i_stat.pipe_busy)) begin
                    o_cmd.th_emit = 1'b1;
                    n_state       = hpt_pkg::ST_IDLE;
                end else if (!r_walk_cnt[hpt_pkg::BIN_W]) begin
                    o_cmd.walk_issue = 1'b1;
                    n_walk_cnt       = r_walk_cnt + 1'b1;
                end
            end
            default: begin
                n_state = hpt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/hpt_dpath.sv]
// hpt_dpath: config registers, bin memory with valid bits, running sum and total,
// threshold accumulate pipeline and result registers; depends on hpt_pkg
module hpt_dpath #(
    parameter int COUNT_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  hpt_pkg::t_cmd                  i_cmd,
    output hpt_pkg::t_stat                 o_stat,
    input  logic [hpt_pkg::PIX_W-1:0]      i_pixel_value,
    input  logic [hpt_pkg::BIN_W-1:0]      i_bin_index,
    input  logic                           i_cfg_we,
    input  logic [hpt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [hpt_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output logic                           o_valid,
    output logic [hpt_pkg::SUM_W-1:0]      o_pixel_sum,
    output logic [hpt_pkg::CNT_OUT_W-1:0]  o_bin_count,
    output logic [hpt_pkg::THR_W-1:0]      o_threshold_bin
);

    localparam int TOT_W = COUNT_BITS + hpt_pkg::BIN_W;
    localparam int ACC_W = TOT_W + hpt_pkg::PCT_W;

    // configuration
    logic [hpt_pkg::DEPTH_W-1:0] r_pixel_depth;
    logic                        r_signed_pixels;
    logic [hpt_pkg::PCT_W-1:0]   r_threshold_percent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_depth       <= hpt_pkg::DEPTH_RESET;
            r_signed_pixels     <= 1'b0;
            r_threshold_percent <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                hpt_pkg::CFG_PIXEL_DEPTH:
                    r_pixel_depth <= i_cfg_wdata[hpt_pkg::DEPTH_W-1:0];
                hpt_pkg::CFG_SIGNED_PIXELS:
                    r_signed_pixels <= i_cfg_wdata[0];
                hpt_pkg::CFG_THRESHOLD_PERCENT:
                    r_threshold_percent <= i_cfg_wdata[hpt_pkg::PCT_W-1:0];
                default: ;
            endcase
        end
    end

    // pixel masking and bin select
    logic [hpt_pkg::DEPTH_W-1:0] w_depth;
    logic [hpt_pkg::PIX_W-1:0]   w_mask, w_pix_v;
    logic [hpt_pkg::BIN_W-1:0]   w_pix_bin;

    always_comb begin
        if (r_pixel_depth < hpt_pkg::DEPTH_MIN)      w_depth = hpt_pkg::DEPTH_MIN;
        else if (r_pixel_depth > hpt_pkg::DEPTH_MAX) w_depth = hpt_pkg::DEPTH_MAX;
        else                                         w_depth = r_pixel_depth;
        w_mask    = {hpt_pkg::PIX_W{1'b1}} >> (hpt_pkg::DEPTH_MAX - w_depth);
        w_pix_v   = i_pixel_value & w_mask;
        w_pix_bin = (w_pix_v[hpt_pkg::PIX_W-1:hpt_pkg::BIN_W] != '0) ?
                    {hpt_pkg::BIN_W{1'b1}} : w_pix_v[hpt_pkg::BIN_W-1:0];
    end

    // halves swap is a flip of the top address bit
    logic                      r_swap;
    logic [hpt_pkg::BIN_W-1:0] w_swap_xor;
    assign w_swap_xor = {r_swap, {(hpt_pkg::BIN_W-1){1'b0}}};

    // bin memory
    logic [COUNT_BITS-1:0]     r_mem [hpt_pkg::NUM_BINS];
    logic [hpt_pkg::NUM_BINS-1:0] r_vld;
    logic [COUNT_BITS-1:0]     r_rd_data;
    logic                      r_rd_vld;
    logic [hpt_pkg::BIN_W-1:0] w_raddr;
    logic [hpt_pkg::BIN_W-1:0] r_pix_addr;
    logic [hpt_pkg::PIX_W-1:0] r_pix_v;
    logic [COUNT_BITS-1:0]     w_cur_cnt;
    logic                      w_cnt_sat;
    logic [COUNT_BITS-1:0]     w_new_cnt;

    always_comb begin
        priority if (i_cmd.pix_load) w_raddr = w_pix_bin ^ w_swap_xor;
        else if (i_cmd.rd_issue)     w_raddr = i_bin_index ^ w_swap_xor;
        else                         w_raddr = i_cmd.walk_addr ^ w_swap_xor;
    end

    assign w_cur_cnt = r_rd_vld ? r_rd_data : '0;
    assign w_cnt_sat = (w_cur_cnt == {COUNT_BITS{1'b1}});
    assign w_new_cnt = w_cnt_sat ? w_cur_cnt : w_cur_cnt + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.pix_upd) r_mem[r_pix_addr] <= w_new_cnt;
        r_rd_data <= r_mem[w_raddr];
        r_rd_vld  <= r_vld[w_raddr];
        if (i_cmd.pix_load) begin
            r_pix_addr <= w_pix_bin ^ w_swap_xor;
            r_pix_v    <= w_pix_v;
        end
    end

    // running sum, total count, valid bits, swap flag
    logic [hpt_pkg::SUM_W-1:0] r_sum, n_sum;
    logic [hpt_pkg::SUM_W:0]   w_sum_wide;
    logic [TOT_W-1:0]          r_total;

    assign w_sum_wide = {1'b0, r_sum} + (hpt_pkg::SUM_W+1)'(r_pix_v);

    always_comb begin
        n_sum = r_sum;
        if (i_cmd.clear) begin
            n_sum = '0;
        end else if (i_cmd.pix_upd) begin
            n_sum = w_sum_wide[hpt_pkg::SUM_W] ? {hpt_pkg::SUM_W{1'b1}}
                                               : w_sum_wide[hpt_pkg::SUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_total <= '0;
            r_vld   <= '0;
            r_swap  <= 1'b0;
        end else begin
            r_sum <= n_sum;
            if (i_cmd.clear) begin
                r_total <= '0;
                r_vld   <= '0;
            end else if (i_cmd.pix_upd) begin
                r_vld[r_pix_addr] <= 1'b1;
                if (!w_cnt_sat) r_total <= r_total + 1'b1;
            end
            if (i_cmd.swap && r_signed_pixels) r_swap <= ~r_swap;
        end
    end

    // threshold walk: compare 100*cumulative against total*(100-percent)
    logic [hpt_pkg::PCT_W-1:0] w_q;
    logic [ACC_W-1:0]          r_tq, r_acc, r_scaled, w_acc_next;
    logic                      r_s1_go, r_s2_go, r_found;
    logic [hpt_pkg::BIN_W-1:0] r_s1_idx, r_s2_idx, r_th_idx;

    assign w_q = (r_threshold_percent > hpt_pkg::PCT_FULL) ? '0
                 : hpt_pkg::PCT_FULL - r_threshold_percent;
    assign w_acc_next = r_acc + r_scaled;

    always_ff @(posedge i_clk) begin
        if (i_cmd.th_init) r_tq <= ACC_W'(r_total) * ACC_W'(w_q);
        r_s1_idx <= i_cmd.walk_addr;
        r_s2_idx <= r_s1_idx;
        r_scaled <= ACC_W'(w_cur_cnt) * ACC_W'(hpt_pkg::PCT_FULL);
        if (i_cmd.th_init) begin
            r_acc <= '0;
        end else if (r_s2_go && !r_found) begin
            r_acc <= w_acc_next;
            if (w_acc_next > r_tq) r_th_idx <= r_s2_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_go <= 1'b0;
            r_s2_go <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_s1_go <= i_cmd.walk_issue;
            r_s2_go <= r_s1_go;
            if (i_cmd.th_init) begin
                r_found <= 1'b0;
            end else if (r_s2_go && !r_found && (w_acc_next > r_tq)) begin
                r_found <= 1'b1;
            end
        end
    end

    assign o_stat.found     = r_found;
    assign o_stat.pipe_busy = r_s1_go | r_s2_go;

    // result word
    logic [hpt_pkg::THR_W-1:0] w_thr;

    always_comb begin
        if (!r_found)            w_thr = hpt_pkg::THR_NONE;
        else if (r_th_idx == '0) w_thr = hpt_pkg::THR_MIN;
        else                     w_thr = hpt_pkg::THR_W'(r_th_idx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.emit_now | i_cmd.pix_upd | i_cmd.rd_emit | i_cmd.th_emit;
        end
        o_pixel_sum     <= n_sum;
        o_bin_count     <= i_cmd.rd_emit ? hpt_pkg::CNT_OUT_W'(w_cur_cnt) : '0;
        o_threshold_bin <= i_cmd.th_emit ? w_thr : '0;
    end

endmodule

[rtl/core/histogram_with_percentile_threshold_unit.sv]
// results: clear, end frame and unused kinds answer straight from idle; pixel and bin read
// pass through ST_PIX or ST_READ; threshold walks one bin per cycle through the walk pipeline
// throughput: one word at a time, start taken only while busy is low
// the result strobe is one cycle wide and cannot be stalled
// synchronous active-low reset clears bins (valid bits), sum and swap and resets config at once
// instantiates hpt_ctrl and hpt_dpath; depends on hpt_pkg
module histogram_with_percentile_threshold_unit #(
    parameter int COUNT_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [hpt_pkg::KIND_W-1:0]     i_kind,
    input  logic [hpt_pkg::PIX_W-1:0]      i_pixel_value,
    input  logic [hpt_pkg::BIN_W-1:0]      i_bin_index,
    input  logic                           i_cfg_we,
    input  logic [hpt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [hpt_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output logic                           o_busy,
    output logic                           o_valid,
    output logic [hpt_pkg::SUM_W-1:0]      o_pixel_sum,
    output logic [hpt_pkg::CNT_OUT_W-1:0]  o_bin_count,
    output logic [hpt_pkg::THR_W-1:0]      o_threshold_bin
);

    hpt_pkg::t_cmd  w_cmd;
    hpt_pkg::t_stat w_stat;

    hpt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_kind  (i_kind),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (o_busy)
    );

    hpt_dpath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_pixel_value   (i_pixel_value),
        .i_bin_index     (i_bin_index),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_valid         (o_valid),
        .o_pixel_sum     (o_pixel_sum),
        .o_bin_count     (o_bin_count),
        .o_threshold_bin (o_threshold_bin)
    );

endmodule
